// File: src/vcu_pkg.sv
// ============================================================================
// vcu_pkg - shared types and constants of the vector clock unit
// Holds the command and result payload types, the configuration view and the
// codes used by the sequencer and the register block.
// ============================================================================
package vcu_pkg;

    // Fixed field widths of the command, result and configuration ports.
    localparam int ACTION_W    = 2;
    localparam int NODE_W      = 4;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OWN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

    // Reset values of the configuration registers.
    localparam logic               MODE_RST  = 1'b0;
    localparam logic [NODE_W-1:0]  OWN_RST   = 4'd0;
    localparam logic [COUNT_W-1:0] COUNT_RST = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INTERNAL = 2'd0,
        ACT_SEND     = 2'd1,
        ACT_RECEIVE  = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OWN,
        S_TICK,
        S_RX_RD,
        S_RX_MERGE,
        S_WALK,
        S_WALK_END,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NODE_W-1:0]   dest_node;
        logic [NODE_W-1:0]   entry_index;
        logic [VALUE_W-1:0]  entry_value;
        logic                first_entry;
    } cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0]  out_index;
        logic [VALUE_W-1:0] out_value;
        logic               last_entry;
    } result_t;

    typedef struct packed {
        logic               mode;
        logic [NODE_W-1:0]  own_node;
        logic [COUNT_W-1:0] node_count;
    } cfg_t;

endpackage

// File: src/vcu_ram.sv
// ============================================================================
// vcu_ram - synchronous table with one write and one registered read port
// Rows that were never written since reset read as zero, tracked by one
// valid flop per row.
// ============================================================================
module vcu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] row_vld_reg;
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (we)
        begin
            row_vld_reg[waddr] <= 1'b1;
        end
    end

    // Read returns the old contents when the same row is written this cycle.
    always_ff @(posedge clk)
    begin
        rdata_reg <= row_vld_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

// File: src/vcu_seq.sv
// ============================================================================
// vcu_seq - command sequencer of the vector clock unit
// Reads, updates and writes back the clock and last-sent tables one row per
// cycle and produces the result transfers.
// ============================================================================
module vcu_seq #(
    parameter int MAX_NODES  = 16,
    parameter int CLOCK_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  vcu_pkg::cfg_t                cfg,
    input  logic                         start,
    input  vcu_pkg::cmd_t                cmd,
    output logic                         busy,
    output logic                         result_valid,
    output vcu_pkg::result_t             result,
    output logic                         cvm_we,
    output logic [$clog2(MAX_NODES)-1:0] cvm_waddr,
    output logic [2*CLOCK_BITS-1:0]      cvm_wdata,
    output logic [$clog2(MAX_NODES)-1:0] cvm_raddr,
    input  logic [2*CLOCK_BITS-1:0]      cvm_rdata,
    output logic                         lsm_we,
    output logic [$clog2(MAX_NODES)-1:0] lsm_waddr,
    output logic [CLOCK_BITS-1:0]        lsm_wdata,
    output logic [$clog2(MAX_NODES)-1:0] lsm_raddr,
    input  logic [CLOCK_BITS-1:0]        lsm_rdata
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam logic [CLOCK_BITS-1:0] CLK_MAX = '1;

    vcu_pkg::state_t  state_reg, state_next;
    vcu_pkg::action_t act_reg, act_next;
    logic [IDX_W-1:0]          dest_reg, dest_next;
    logic [vcu_pkg::NODE_W-1:0] idx_reg, idx_next;
    logic                      idx_ok_reg, idx_ok_next;
    logic [CLOCK_BITS-1:0]     val_reg, val_next;
    logic                      first_reg, first_next;
    logic                      mode_reg, mode_next;
    logic [CNT_W-1:0]          n_reg, n_next;
    logic [IDX_W-1:0]          own_reg, own_next;
    logic [CLOCK_BITS-1:0]     own_clk_reg, own_clk_next;
    logic [CLOCK_BITS-1:0]     bar_reg, bar_next;
    logic [IDX_W-1:0]          walk_idx_reg, walk_idx_next;
    logic                      chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]          chk_idx_reg, chk_idx_next;
    logic                      pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]          pend_idx_reg, pend_idx_next;
    logic [CLOCK_BITS-1:0]     pend_val_reg, pend_val_next;
    logic                      out_vld_reg, out_vld_next;
    vcu_pkg::result_t          out_reg, out_next;

    logic [CNT_W-1:0]      n_cur;
    logic [IDX_W-1:0]      own_cur;
    logic                  item_ok;
    logic [CLOCK_BITS-1:0] rd_cv;
    logic [CLOCK_BITS-1:0] rd_lu;
    logic [CLOCK_BITS-1:0] ticked;
    logic                  do_tick;
    logic                  walk_last;
    logic [CLOCK_BITS-1:0] merge_lu;

    // Effective node count and own index from the configuration registers.
    always_comb
    begin
        if (cfg.node_count == '0)
        begin
            n_cur = CNT_W'(1);
        end
        else if (int'(cfg.node_count) > MAX_NODES)
        begin
            n_cur = CNT_W'(MAX_NODES);
        end
        else
        begin
            n_cur = CNT_W'(cfg.node_count);
        end
        own_cur = (int'(cfg.own_node) < int'(n_cur)) ? IDX_W'(cfg.own_node)
                                                     : IDX_W'(n_cur - CNT_W'(1));
    end

    // A send to an unused destination and an unknown action are dropped.
    always_comb
    begin
        unique case (cmd.action)
            vcu_pkg::ACT_INTERNAL: item_ok = 1'b1;
            vcu_pkg::ACT_RECEIVE:  item_ok = 1'b1;
            vcu_pkg::ACT_SEND:     item_ok = int'(cmd.dest_node) < int'(n_cur);
            default:               item_ok = 1'b0;
        endcase
    end

    assign rd_cv     = cvm_rdata[CLOCK_BITS-1:0];
    assign rd_lu     = cvm_rdata[2*CLOCK_BITS-1:CLOCK_BITS];
    assign do_tick   = (act_reg != vcu_pkg::ACT_RECEIVE) || first_reg;
    assign ticked    = (do_tick && (rd_cv != CLK_MAX)) ? rd_cv + CLOCK_BITS'(1) : rd_cv;
    assign walk_last = CNT_W'(walk_idx_reg) == (n_reg - CNT_W'(1));
    assign merge_lu  = !mode_reg ? rd_lu
                     : (IDX_W'(idx_reg) == own_reg) ? val_reg : own_clk_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vcu_pkg::S_IDLE:
            begin
                if (start && item_ok)
                begin
                    state_next = vcu_pkg::S_RD_OWN;
                end
            end
            vcu_pkg::S_RD_OWN:
            begin
                state_next = vcu_pkg::S_TICK;
            end
            vcu_pkg::S_TICK:
            begin
                unique case (act_reg)
                    vcu_pkg::ACT_SEND:    state_next = vcu_pkg::S_WALK;
                    vcu_pkg::ACT_RECEIVE: state_next = idx_ok_reg ? vcu_pkg::S_RX_RD
                                                                  : vcu_pkg::S_IDLE;
                    default:              state_next = vcu_pkg::S_IDLE;
                endcase
            end
            vcu_pkg::S_RX_RD:
            begin
                state_next = vcu_pkg::S_RX_MERGE;
            end
            vcu_pkg::S_RX_MERGE:
            begin
                state_next = vcu_pkg::S_IDLE;
            end
            vcu_pkg::S_WALK:
            begin
                if (walk_last)
                begin
                    state_next = vcu_pkg::S_WALK_END;
                end
            end
            vcu_pkg::S_WALK_END:
            begin
                state_next = vcu_pkg::S_FLUSH;
            end
            vcu_pkg::S_FLUSH:
            begin
                state_next = vcu_pkg::S_IDLE;
            end
        endcase
    end

    // Table accesses and register updates.
    always_comb
    begin
        act_next      = act_reg;
        dest_next     = dest_reg;
        idx_next      = idx_reg;
        idx_ok_next   = idx_ok_reg;
        val_next      = val_reg;
        first_next    = first_reg;
        mode_next     = mode_reg;
        n_next        = n_reg;
        own_next      = own_reg;
        own_clk_next  = own_clk_reg;
        bar_next      = bar_reg;
        walk_idx_next = walk_idx_reg;
        chk_vld_next  = (state_reg == vcu_pkg::S_WALK);
        chk_idx_next  = walk_idx_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        pend_val_next = pend_val_reg;
        out_vld_next  = 1'b0;
        out_next      = out_reg;

        cvm_we    = 1'b0;
        cvm_waddr = own_reg;
        cvm_wdata = {rd_lu, ticked};
        cvm_raddr = own_reg;
        lsm_we    = 1'b0;
        lsm_waddr = dest_reg;
        lsm_wdata = ticked;
        lsm_raddr = dest_reg;

        unique case (state_reg)
            vcu_pkg::S_IDLE:
            begin
                act_next    = vcu_pkg::action_t'(cmd.action);
                dest_next   = IDX_W'(cmd.dest_node);
                idx_next    = cmd.entry_index;
                idx_ok_next = int'(cmd.entry_index) < int'(n_cur);
                val_next    = (64'(cmd.entry_value) > 64'(CLK_MAX))
                              ? CLK_MAX : CLOCK_BITS'(cmd.entry_value);
                first_next  = cmd.first_entry;
                mode_next   = cfg.mode;
                n_next      = n_cur;
                own_next    = own_cur;
            end
            vcu_pkg::S_RD_OWN:
            begin
                pend_vld_next = 1'b0;
            end
            vcu_pkg::S_TICK:
            begin
                own_clk_next  = ticked;
                bar_next      = lsm_rdata;
                walk_idx_next = '0;
                if (do_tick)
                begin
                    cvm_we    = 1'b1;
                    cvm_wdata = {mode_reg ? ticked : rd_lu, ticked};
                end
                if ((act_reg == vcu_pkg::ACT_SEND) && mode_reg)
                begin
                    lsm_we = 1'b1;
                end
                if (act_reg == vcu_pkg::ACT_INTERNAL)
                begin
                    out_vld_next        = 1'b1;
                    out_next.out_index  = vcu_pkg::NODE_W'(own_reg);
                    out_next.out_value  = vcu_pkg::VALUE_W'(ticked);
                    out_next.last_entry = 1'b1;
                end
                else if ((act_reg == vcu_pkg::ACT_RECEIVE) && !idx_ok_reg)
                begin
                    out_vld_next        = 1'b1;
                    out_next.out_index  = idx_reg;
                    out_next.out_value  = '0;
                    out_next.last_entry = 1'b1;
                end
            end
            vcu_pkg::S_RX_RD:
            begin
                cvm_raddr = IDX_W'(idx_reg);
            end
            vcu_pkg::S_RX_MERGE:
            begin
                cvm_waddr           = IDX_W'(idx_reg);
                cvm_wdata           = {merge_lu, val_reg};
                out_vld_next        = 1'b1;
                out_next.out_index  = idx_reg;
                out_next.last_entry = 1'b1;
                if (rd_cv < val_reg)
                begin
                    cvm_we             = 1'b1;
                    out_next.out_value = vcu_pkg::VALUE_W'(val_reg);
                end
                else
                begin
                    out_next.out_value = vcu_pkg::VALUE_W'(rd_cv);
                end
            end
            vcu_pkg::S_WALK:
            begin
                cvm_raddr     = walk_idx_reg;
                walk_idx_next = walk_idx_reg + IDX_W'(1);
            end
            vcu_pkg::S_WALK_END:
            begin
            end
            vcu_pkg::S_FLUSH:
            begin
                if (pend_vld_reg)
                begin
                    out_vld_next        = 1'b1;
                    out_next.out_index  = vcu_pkg::NODE_W'(pend_idx_reg);
                    out_next.out_value  = vcu_pkg::VALUE_W'(pend_val_reg);
                    out_next.last_entry = 1'b1;
                    pend_vld_next       = 1'b0;
                end
            end
        endcase

        // A walked row that qualifies pushes the one held back before it, so
        // the final one can still be marked as last when the walk ends.
        if (chk_vld_reg && (!mode_reg || (rd_lu > bar_reg)))
        begin
            if (pend_vld_reg)
            begin
                out_vld_next        = 1'b1;
                out_next.out_index  = vcu_pkg::NODE_W'(pend_idx_reg);
                out_next.out_value  = vcu_pkg::VALUE_W'(pend_val_reg);
                out_next.last_entry = 1'b0;
            end
            pend_vld_next = 1'b1;
            pend_idx_next = chk_idx_reg;
            pend_val_next = rd_cv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vcu_pkg::S_IDLE;
            chk_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_vld_reg  <= chk_vld_next;
            pend_vld_reg <= pend_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        dest_reg     <= dest_next;
        idx_reg      <= idx_next;
        idx_ok_reg   <= idx_ok_next;
        val_reg      <= val_next;
        first_reg    <= first_next;
        mode_reg     <= mode_next;
        n_reg        <= n_next;
        own_reg      <= own_next;
        own_clk_reg  <= own_clk_next;
        bar_reg      <= bar_next;
        walk_idx_reg <= walk_idx_next;
        chk_idx_reg  <= chk_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_val_reg <= pend_val_next;
        out_reg      <= out_next;
    end

    assign busy         = (state_reg != vcu_pkg::S_IDLE);
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

// File: src/vector_clock_unit.sv
// ============================================================================
// vector_clock_unit - vector clock of one process with differential sends
// An internal event or an out-of-range receive shows its result from the own-row
// step, an in-range receive after its entry row is read and merged.
// A send walks the clock table one row per cycle over the n nodes in use.
// Reset: rst_n clears the registers and all table rows read as zero after it.
// ============================================================================
module vector_clock_unit #(
    parameter int MAX_NODES  = 16,
    parameter int CLOCK_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [vcu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vcu_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               start,
    input  vcu_pkg::cmd_t                      cmd,
    output logic                               busy,
    output logic                               result_valid,
    output vcu_pkg::result_t                   result
);

    // The clock table holds, per node, the clock value in the low half of a
    // row and the last-update time in the high half, so that one read gives
    // everything a send walk needs for that node. The last-sent table is a
    // second memory addressed by destination node.
    localparam int IDX_W = $clog2(MAX_NODES);

    logic                    mode_reg;
    logic [vcu_pkg::NODE_W-1:0]  own_reg;
    logic [vcu_pkg::COUNT_W-1:0] count_reg;
    vcu_pkg::cfg_t           cfg;

    logic                    cvm_we;
    logic [IDX_W-1:0]        cvm_waddr;
    logic [2*CLOCK_BITS-1:0] cvm_wdata;
    logic [IDX_W-1:0]        cvm_raddr;
    logic [2*CLOCK_BITS-1:0] cvm_rdata;
    logic                    lsm_we;
    logic [IDX_W-1:0]        lsm_waddr;
    logic [CLOCK_BITS-1:0]   lsm_wdata;
    logic [IDX_W-1:0]        lsm_raddr;
    logic [CLOCK_BITS-1:0]   lsm_rdata;

    // Configuration registers. Writes to an unused index are dropped. The
    // sequencer takes a snapshot of the decoded values when a command is
    // accepted, so the registers are only meant to change while idle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= vcu_pkg::MODE_RST;
            own_reg   <= vcu_pkg::OWN_RST;
            count_reg <= vcu_pkg::COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vcu_pkg::REG_MODE:  mode_reg  <= cfg_data[0];
                vcu_pkg::REG_OWN:   own_reg   <= cfg_data[vcu_pkg::NODE_W-1:0];
                vcu_pkg::REG_COUNT: count_reg <= cfg_data[vcu_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = {mode_reg, own_reg, count_reg};

    // Clock value and last-update time per node.
    vcu_ram #(
        .WIDTH (2 * CLOCK_BITS),
        .DEPTH (MAX_NODES)
    ) u_clock_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cvm_we),
        .waddr (cvm_waddr),
        .wdata (cvm_wdata),
        .raddr (cvm_raddr),
        .rdata (cvm_rdata)
    );

    // Own clock at the last send to each destination.
    vcu_ram #(
        .WIDTH (CLOCK_BITS),
        .DEPTH (MAX_NODES)
    ) u_sent_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (lsm_we),
        .waddr (lsm_waddr),
        .wdata (lsm_wdata),
        .raddr (lsm_raddr),
        .rdata (lsm_rdata)
    );

    // The sequencer reads the own row, ticks it unless it is a later entry of a
    // receive, then reports it, merges one received entry, or walks all used
    // rows for a send. Results leave through a register, one transfer per cycle
    // at most, and the next command can be accepted in the final result's cycle.
    vcu_seq #(
        .MAX_NODES  (MAX_NODES),
        .CLOCK_BITS (CLOCK_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result),
        .cvm_we       (cvm_we),
        .cvm_waddr    (cvm_waddr),
        .cvm_wdata    (cvm_wdata),
        .cvm_raddr    (cvm_raddr),
        .cvm_rdata    (cvm_rdata),
        .lsm_we       (lsm_we),
        .lsm_waddr    (lsm_waddr),
        .lsm_wdata    (lsm_wdata),
        .lsm_raddr    (lsm_raddr),
        .lsm_rdata    (lsm_rdata)
    );

endmodule

// File: src/vcu_checker.sv
// ============================================================================
// vcu_checker - port-level checks of the vector clock unit
// Watches the command and result transfers for ordering slips.
// ============================================================================
module vcu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             result_valid,
    input vcu_pkg::result_t result
);

    // The table read after a start transfer leaves no result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_valid)
    else $error("result transfer right after a start transfer");

    // A final result closes its command: nothing follows in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_entry) |=> !result_valid)
    else $error("result transfer right after a final result");

    // More results of a send are still to come, so the unit stays busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_entry) |-> busy)
    else $error("non-final result while idle");

    // After a non-final result the walk goes on, or the final result shows.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_entry) |=> (busy || result_valid))
    else $error("unit went idle with a send still open");

endmodule

bind vector_clock_unit vcu_checker u_vcu_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .result       (result)
);
